// ----- src/mtr_pkg.sv -----
// Shared types, codes and arithmetic helpers for the media timestamp rebaser.
// Used by mtr_core and media_timestamp_rebaser; depends on nothing else.
package mtr_pkg;

  localparam int unsigned TimeW = 64;
  localparam int unsigned RegW  = 40;
  localparam int unsigned ApbDW = 64;
  localparam int unsigned ApbAW = 5;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  // Register reset values
  localparam logic [RegW-1:0] WarmupTimeRst    = RegW'(500000000);
  localparam logic [RegW-1:0] OutputLeadRst    = RegW'(200000000);
  localparam logic [RegW-1:0] LateLimitRst     = RegW'(1000000000);
  localparam logic [RegW-1:0] MismatchLimitRst = RegW'(1000000000);

  typedef enum logic [1:0] {
    REG_WARMUP_TIME    = 2'd0,
    REG_OUTPUT_LEAD    = 2'd1,
    REG_LATE_LIMIT     = 2'd2,
    REG_MISMATCH_LIMIT = 2'd3
  } mtr_reg_e;

  typedef enum logic [2:0] {
    OP_SESSION = 3'd0,
    OP_OFFER   = 3'd1,
    OP_POLL    = 3'd2,
    OP_MAP     = 3'd3,
    OP_PROJECT = 3'd4
  } mtr_op_e;

  typedef enum logic [3:0] {
    ST_MAPPED      = 4'd0,
    ST_DROPPED     = 4'd1,
    ST_EPOCH_RESET = 4'd2,
    ST_NOT_READY   = 4'd3,
    ST_NEW_SESSION = 4'd4,
    ST_DUPLICATE   = 4'd5,
    ST_WARMING     = 4'd6,
    ST_READY       = 4'd7,
    ST_OFFER_DONE  = 4'd8
  } mtr_status_e;

  typedef struct packed {
    logic [RegW-1:0] warmup_time;
    logic [RegW-1:0] output_lead;
    logic [RegW-1:0] late_limit;
    logic [RegW-1:0] mismatch_limit;
  } mtr_cfg_t;

  typedef struct packed {
    logic [2:0]       op;
    logic             kind;
    logic [TimeW-1:0] generation;
    logic [TimeW-1:0] src;
    logic [TimeW-1:0] arr;
    logic [TimeW-1:0] now;
  } mtr_item_t;

  typedef struct packed {
    mtr_status_e      status;
    logic             mvalid;
    logic [TimeW-1:0] mtime;
  } mtr_result_t;

  // Index 0 is audio, index 1 is video
  typedef struct packed {
    logic                  have_gen;
    logic [TimeW-1:0]      cur_gen;
    logic [1:0]            first_seen;
    logic [1:0][TimeW-1:0] first_src;
    logic [TimeW-1:0]      warmup_start;
    logic                  ready;
    logic [TimeW-1:0]      source_origin;
    logic [TimeW-1:0]      output_base;
    logic                  floor_valid;
    logic [TimeW-1:0]      output_floor;
    logic [1:0]            prev_valid;
    logic [1:0][TimeW-1:0] prev_src;
    logic [1:0][TimeW-1:0] prev_arr;
    logic [1:0]            sfloor_valid;
    logic [1:0][TimeW-1:0] sfloor;
  } mtr_state_t;

  function automatic logic [TimeW-1:0] abs_diff(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Output origin: now + lead saturated, then pushed above the shared floor
  function automatic logic [TimeW-1:0] new_origin(input logic [TimeW-1:0] now,
                                                  input logic [RegW-1:0]  lead,
                                                  input logic             fvalid,
                                                  input logic [TimeW-1:0] floor_t);
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] o;
    sum = {1'b0, now} + {{(TimeW-RegW+1){1'b0}}, lead};
    o   = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
    if (fvalid && (o <= floor_t)) begin
      o = (floor_t == TimeMax) ? TimeMax : floor_t + TimeW'(1);
    end
    return o;
  endfunction

endpackage

// ----- src/mtr_core.sv -----
// Next-state and result logic of the rebaser for one operation.
// Purely combinational; depends on mtr_pkg.
module mtr_core (
  input  mtr_pkg::mtr_state_t  state_i,
  input  mtr_pkg::mtr_item_t   item_i,
  input  mtr_pkg::mtr_cfg_t    cfg_i,
  output mtr_pkg::mtr_state_t  state_o,
  output mtr_pkg::mtr_result_t result_o
);
  import mtr_pkg::*;

  logic             k;
  logic             audio;
  logic [TimeW-1:0] origin;
  logic [TimeW-1:0] src_delta;
  logic [TimeW:0]   map_sum;
  logic             map_ovf;
  logic [TimeW-1:0] mapped;
  logic             late_back;
  logic             mismatch;
  logic             late_now;
  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] late_lim;
  logic [TimeW-1:0] mism_lim;

  assign k        = item_i.kind;
  assign audio    = ~item_i.kind;
  assign late_lim = {{(TimeW-RegW){1'b0}}, cfg_i.late_limit};
  assign mism_lim = {{(TimeW-RegW){1'b0}}, cfg_i.mismatch_limit};

  // Epoch restart origin, from the floor as it stands before this item
  assign origin = new_origin(item_i.now, cfg_i.output_lead,
                             state_i.floor_valid, state_i.output_floor);

  // Source time projected onto the output line
  assign src_delta = item_i.src - state_i.source_origin;
  assign map_sum   = {1'b0, state_i.output_base} + {1'b0, src_delta};
  assign map_ovf   = (item_i.src < state_i.source_origin) || map_sum[TimeW];
  assign mapped    = map_sum[TimeW-1:0];
  assign late_now  = (item_i.now > mapped) && ((item_i.now - mapped) > late_lim);

  // Checks against the previous packet of this stream
  assign late_back = state_i.prev_valid[k] && (item_i.src < state_i.prev_src[k]) &&
                     ((state_i.prev_src[k] - item_i.src) > late_lim);
  assign mismatch  = state_i.prev_valid[k] &&
                     (abs_diff(abs_diff(item_i.src, state_i.prev_src[k]),
                               abs_diff(item_i.arr, state_i.prev_arr[k])) > mism_lim);

  assign elapsed = (item_i.now >= state_i.warmup_start) ?
                   (item_i.now - state_i.warmup_start) : '0;

  always_comb begin
    state_o  = state_i;
    result_o = '{status: ST_NOT_READY, mvalid: 1'b0, mtime: '0};
    unique case (item_i.op)
      OP_SESSION: begin
        if (state_i.have_gen && (state_i.cur_gen == item_i.generation)) begin
          result_o.status = ST_DUPLICATE;
        end else begin
          state_o.cur_gen      = item_i.generation;
          state_o.have_gen     = 1'b1;
          state_o.ready        = 1'b0;
          state_o.first_seen   = '0;
          state_o.prev_valid   = '0;
          state_o.sfloor_valid = '0;
          result_o.status      = ST_NEW_SESSION;
        end
      end
      OP_OFFER: begin
        if (!state_i.first_seen[k]) begin
          state_o.first_seen[k] = 1'b1;
          state_o.first_src[k]  = item_i.src;
          if (audio || (state_i.warmup_start == '0) ||
              (item_i.arr < state_i.warmup_start)) begin
            state_o.warmup_start = item_i.arr;
          end
        end
        result_o.status = ST_OFFER_DONE;
      end
      OP_POLL: begin
        if (state_i.first_seen == 2'b00) begin
          result_o.status = ST_WARMING;
        end else if (state_i.ready) begin
          result_o.status = ST_READY;
        end else if ((state_i.first_seen != 2'b11) &&
                     (elapsed < {{(TimeW-RegW){1'b0}}, cfg_i.warmup_time})) begin
          result_o.status = ST_WARMING;
        end else begin
          // Latch origins: earliest first source time of the streams seen
          priority if (state_i.first_seen == 2'b11) begin
            state_o.source_origin = (state_i.first_src[0] < state_i.first_src[1]) ?
                                    state_i.first_src[0] : state_i.first_src[1];
          end else if (state_i.first_seen[0]) begin
            state_o.source_origin = state_i.first_src[0];
          end else begin
            state_o.source_origin = state_i.first_src[1];
          end
          state_o.output_base = new_origin(item_i.now, cfg_i.output_lead,
                                           state_i.floor_valid, state_i.output_floor);
          state_o.ready   = 1'b1;
          result_o.status = ST_READY;
        end
      end
      OP_MAP: begin
        if (!state_i.ready) begin
          result_o.status = ST_NOT_READY;
        end else if (late_back) begin
          result_o.status = ST_DROPPED;
        end else if (mismatch) begin
          if (audio) begin
            result_o.status = ST_DROPPED;
          end else begin
            // Clock discontinuity on video: new epoch
            state_o.prev_src[k]   = item_i.src;
            state_o.prev_arr[k]   = item_i.arr;
            state_o.source_origin = item_i.src;
            state_o.output_base   = origin;
            state_o.floor_valid   = 1'b1;
            state_o.output_floor  = origin;
            result_o = '{status: ST_EPOCH_RESET, mvalid: 1'b1, mtime: origin};
          end
        end else begin
          if (!audio) begin
            state_o.prev_src[k]   = item_i.src;
            state_o.prev_arr[k]   = item_i.arr;
            state_o.prev_valid[k] = 1'b1;
          end
          if (map_ovf) begin
            if (audio) begin
              result_o.status = ST_DROPPED;
            end else begin
              state_o.source_origin = item_i.src;
              state_o.output_base   = origin;
              state_o.floor_valid   = 1'b1;
              state_o.output_floor  = origin;
              result_o = '{status: ST_EPOCH_RESET, mvalid: 1'b1, mtime: origin};
            end
          end else begin
            result_o.mvalid = 1'b1;
            result_o.mtime  = mapped;
            priority if (state_i.sfloor_valid[k] && (mapped < state_i.sfloor[k])) begin
              result_o.status = ST_DROPPED;
            end else if (audio && late_now) begin
              result_o.status = ST_DROPPED;
            end else begin
              state_o.sfloor_valid[k] = 1'b1;
              state_o.sfloor[k]       = mapped;
              state_o.floor_valid     = 1'b1;
              if (mapped > state_i.output_floor) begin
                state_o.output_floor = mapped;
              end
              if (late_now) begin
                result_o.status = ST_DROPPED;
              end else begin
                if (audio) begin
                  state_o.prev_src[k]   = item_i.src;
                  state_o.prev_arr[k]   = item_i.arr;
                  state_o.prev_valid[k] = 1'b1;
                end
                result_o.status = ST_MAPPED;
              end
            end
          end
        end
      end
      OP_PROJECT: begin
        if (!state_i.ready) begin
          result_o.status = ST_NOT_READY;
        end else if (map_ovf) begin
          result_o.status = ST_DROPPED;
        end else begin
          result_o = '{status: ST_MAPPED, mvalid: 1'b1, mtime: mapped};
        end
      end
      default: begin
        result_o.status = ST_NOT_READY;
      end
    endcase
  end

endmodule

// ----- src/media_timestamp_rebaser.sv -----
// Top level of the media timestamp rebaser: input register, state, result register, APB.
// Depends on mtr_pkg and mtr_core.
//
// The rebaser takes one operation per cycle while the output is not stalled (session start,
// first-packet offer, readiness poll, map, history projection) and returns exactly one
// result for each. An item is held in an input register, then a single pass of mtr_core
// computes its result and the new session state, which are stored together in the result
// register and the session state register. A stalled result holds the item in the input
// register and stalls the input channel. The four 40-bit registers sit on a 64-bit APB
// port at byte addresses 0, 8, 16 and 24 and may be written only while no item
// is in flight.
module media_timestamp_rebaser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mtr_pkg::ApbAW-1:0]  paddr,
  input  logic [mtr_pkg::ApbDW-1:0]  pwdata,
  output logic [mtr_pkg::ApbDW-1:0]  prdata,
  output logic                       pready,
  // Input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 operation_i,
  input  logic                       media_kind_i,
  input  logic [mtr_pkg::TimeW-1:0]  generation_i,
  input  logic [mtr_pkg::TimeW-1:0]  source_time_i,
  input  logic [mtr_pkg::TimeW-1:0]  arrival_time_i,
  input  logic [mtr_pkg::TimeW-1:0]  now_time_i,
  // Output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 status_o,
  output logic                       mapped_valid_o,
  output logic [mtr_pkg::TimeW-1:0]  mapped_time_o
);
  import mtr_pkg::*;

  mtr_cfg_t    cfg_q;
  mtr_item_t   item_q;
  logic        item_valid_q;
  mtr_state_t  state_q;
  mtr_state_t  state_d;
  mtr_result_t res_d;
  mtr_result_t res_q;
  logic        res_valid_q;
  logic        in_xfer;
  logic        advance;
  logic        cfg_wr;
  mtr_reg_e    reg_sel;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = mtr_reg_e'(paddr[ApbAW-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{warmup_time: WarmupTimeRst, output_lead: OutputLeadRst,
                 late_limit: LateLimitRst, mismatch_limit: MismatchLimitRst};
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WARMUP_TIME:    cfg_q.warmup_time    <= pwdata[RegW-1:0];
        REG_OUTPUT_LEAD:    cfg_q.output_lead    <= pwdata[RegW-1:0];
        REG_LATE_LIMIT:     cfg_q.late_limit     <= pwdata[RegW-1:0];
        REG_MISMATCH_LIMIT: cfg_q.mismatch_limit <= pwdata[RegW-1:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WARMUP_TIME:    prdata = ApbDW'(cfg_q.warmup_time);
      REG_OUTPUT_LEAD:    prdata = ApbDW'(cfg_q.output_lead);
      REG_LATE_LIMIT:     prdata = ApbDW'(cfg_q.late_limit);
      REG_MISMATCH_LIMIT: prdata = ApbDW'(cfg_q.mismatch_limit);
      default:            prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the result register is free or draining
  assign advance    = item_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_xfer) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  // Input payload register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= '{op: operation_i, kind: media_kind_i, generation: generation_i,
                  src: source_time_i, arr: arrival_time_i, now: now_time_i};
    end
  end

  mtr_core u_core (
    .state_i  (state_q),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign status_o       = res_q.status;
  assign mapped_valid_o = res_q.mvalid;
  assign mapped_time_o  = res_q.mtime;

  // Checks
  a_time_zero_when_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mapped_valid_o |-> mapped_time_o == '0)
    else $error("mapped_time nonzero without mapped_valid");

  a_epoch_carries_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EPOCH_RESET || status_o == ST_MAPPED) |-> mapped_valid_o)
    else $error("mapped or epoch result without a time");

  a_session_clears_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.status == ST_NEW_SESSION |=> !state_q.ready)
    else $error("ready flag survived a new session");

  a_floor_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.floor_valid |=> state_q.floor_valid)
    else $error("shared output floor lost its valid flag");

endmodule

// ----- tb/sv/mtr_checker.sv -----
// Scoreboard for the media timestamp rebaser: follows the APB writes and both channels,
// predicts one result per input transfer and compares the results in order.
// Depends on mtr_pkg for the item, result, status and register types.
module mtr_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB, observed only
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [mtr_pkg::ApbAW-1:0]   paddr_i,
  input  logic [mtr_pkg::ApbDW-1:0]   pwdata_i,
  input  logic                        pready_i,
  // Input channel
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [2:0]                  operation_i,
  input  logic                        media_kind_i,
  input  logic [mtr_pkg::TimeW-1:0]   generation_i,
  input  logic [mtr_pkg::TimeW-1:0]   source_time_i,
  input  logic [mtr_pkg::TimeW-1:0]   arrival_time_i,
  input  logic [mtr_pkg::TimeW-1:0]   now_time_i,
  // Output channel
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [3:0]                  status_i,
  input  logic                        mapped_valid_i,
  input  logic [mtr_pkg::TimeW-1:0]   mapped_time_i,
  // To the testbench top
  output int unsigned                 errors_o,
  output int unsigned                 outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import mtr_pkg::*;

  typedef logic [TimeW-1:0] stamp_t;

  // Configuration copy
  logic [RegW-1:0] warmup_ns, lead_ns, late_ns, mismatch_ns;

  // Session and timeline state, index 0 audio, 1 video
  logic       have_gen;
  stamp_t     cur_gen;
  logic [1:0] seen;
  stamp_t     first_src [2];
  stamp_t     warm_start;
  logic       is_ready;
  stamp_t     src_org, out_org;
  logic       floor_ok;
  stamp_t     floor_t;
  logic [1:0] prev_ok;
  stamp_t     prev_src [2];
  stamp_t     prev_arr [2];
  logic [1:0] sfl_ok;
  stamp_t     sfl [2];

  mtr_result_t pending_results [$];
  int unsigned mismatches;

  assign errors_o = mismatches;

  function automatic stamp_t gap(input stamp_t a, input stamp_t b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // now + lead, saturated, then kept strictly above the shared floor
  function automatic stamp_t origin_for(input stamp_t now);
    stamp_t o;
    o = (TimeMax - now < stamp_t'(lead_ns)) ? TimeMax : now + stamp_t'(lead_ns);
    if (floor_ok && o <= floor_t) begin
      o = (floor_t == TimeMax) ? TimeMax : floor_t + stamp_t'(1);
    end
    return o;
  endfunction

  function automatic stamp_t rebase_epoch(input stamp_t src, input stamp_t now);
    stamp_t o;
    o        = origin_for(now);
    src_org  = src;
    out_org  = o;
    floor_ok = 1'b1;
    floor_t  = o;
    return o;
  endfunction

  // One packet onto the output line
  function automatic mtr_status_e map_packet(input logic k, input stamp_t src,
                                             input stamp_t arr, input stamp_t now,
                                             output logic mv, output stamp_t mt);
    stamp_t m;
    logic   audio;
    audio = ~k;  // kind 0 is audio
    mv    = 1'b0;
    mt    = '0;
    if (!is_ready) return ST_NOT_READY;
    if (prev_ok[k]) begin
      if (src < prev_src[k] && prev_src[k] - src > stamp_t'(late_ns)) return ST_DROPPED;
      // source and arrival clocks must advance alike
      if (gap(gap(src, prev_src[k]), gap(arr, prev_arr[k])) > stamp_t'(mismatch_ns)) begin
        if (audio) return ST_DROPPED;
        prev_src[k] = src;
        prev_arr[k] = arr;
        mt = rebase_epoch(src, now);
        mv = 1'b1;
        return ST_EPOCH_RESET;
      end
    end
    if (!audio) begin
      prev_src[k] = src;
      prev_arr[k] = arr;
      prev_ok[k]  = 1'b1;
    end
    // below the origin or past the end of the line
    if (src < src_org || TimeMax - out_org < src - src_org) begin
      if (audio) return ST_DROPPED;
      mt = rebase_epoch(src, now);
      mv = 1'b1;
      return ST_EPOCH_RESET;
    end
    m  = out_org + (src - src_org);
    mt = m;
    mv = 1'b1;
    if (sfl_ok[k] && m < sfl[k]) return ST_DROPPED;
    if (audio && now > m && now - m > stamp_t'(late_ns)) return ST_DROPPED;
    sfl_ok[k] = 1'b1;
    sfl[k]    = m;
    floor_ok  = 1'b1;
    if (m > floor_t) floor_t = m;
    // late video still moves the floors
    if (now > m && now - m > stamp_t'(late_ns)) return ST_DROPPED;
    if (audio) begin
      prev_src[k] = src;
      prev_arr[k] = arr;
      prev_ok[k]  = 1'b1;
    end
    return ST_MAPPED;
  endfunction

  // Expected result of one item, state updated in place
  function automatic mtr_result_t rebase_step(input mtr_item_t it);
    mtr_result_t r;
    stamp_t      el;
    logic        mv;
    stamp_t      mt;
    r.status = ST_NOT_READY;
    r.mvalid = 1'b0;
    r.mtime  = '0;
    case (it.op)
      OP_SESSION: begin
        if (have_gen && cur_gen == it.generation) begin
          r.status = ST_DUPLICATE;
        end else begin
          // shared floor and warmup start survive a new session
          cur_gen  = it.generation;
          have_gen = 1'b1;
          is_ready = 1'b0;
          seen     = '0;
          prev_ok  = '0;
          sfl_ok   = '0;
          r.status = ST_NEW_SESSION;
        end
      end
      OP_OFFER: begin
        if (!seen[it.kind]) begin
          seen[it.kind]      = 1'b1;
          first_src[it.kind] = it.src;
          if (!it.kind || warm_start == '0 || it.arr < warm_start) warm_start = it.arr;
        end
        r.status = ST_OFFER_DONE;
      end
      OP_POLL: begin
        if (seen == '0) begin
          r.status = ST_WARMING;
        end else if (is_ready) begin
          r.status = ST_READY;
        end else begin
          el = (it.now >= warm_start) ? it.now - warm_start : '0;
          if (seen != 2'b11 && el < stamp_t'(warmup_ns)) begin
            r.status = ST_WARMING;
          end else begin
            if (seen == 2'b11) begin
              src_org = (first_src[0] < first_src[1]) ? first_src[0] : first_src[1];
            end else begin
              src_org = seen[0] ? first_src[0] : first_src[1];
            end
            out_org  = origin_for(it.now);
            is_ready = 1'b1;
            r.status = ST_READY;
          end
        end
      end
      OP_MAP: begin
        r.status = map_packet(it.kind, it.src, it.arr, it.now, mv, mt);
        r.mvalid = mv;
        r.mtime  = mt;
      end
      OP_PROJECT: begin
        if (!is_ready) begin
          r.status = ST_NOT_READY;
        end else if (it.src < src_org || TimeMax - out_org < it.src - src_org) begin
          r.status = ST_DROPPED;
        end else begin
          r.status = ST_MAPPED;
          r.mvalid = 1'b1;
          r.mtime  = out_org + (it.src - src_org);
        end
      end
      default: ;  // reserved operations change nothing
    endcase
    return r;
  endfunction

  // Prediction on each input transfer, comparison on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin : track
    mtr_item_t   item;
    mtr_result_t want;
    if (!rst_ni) begin
      warmup_ns   = WarmupTimeRst;
      lead_ns     = OutputLeadRst;
      late_ns     = LateLimitRst;
      mismatch_ns = MismatchLimitRst;
      have_gen    = 1'b0;
      cur_gen     = '0;
      seen        = '0;
      first_src   = '{default: '0};
      warm_start  = '0;
      is_ready    = 1'b0;
      src_org     = '0;
      out_org     = '0;
      floor_ok    = 1'b0;
      floor_t     = '0;
      prev_ok     = '0;
      prev_src    = '{default: '0};
      prev_arr    = '{default: '0};
      sfl_ok      = '0;
      sfl         = '{default: '0};
      pending_results.delete();
      mismatches    = 0;
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (mtr_reg_e'(paddr_i[4:3]))
          REG_WARMUP_TIME:    warmup_ns   = pwdata_i[RegW-1:0];
          REG_OUTPUT_LEAD:    lead_ns     = pwdata_i[RegW-1:0];
          REG_LATE_LIMIT:     late_ns     = pwdata_i[RegW-1:0];
          REG_MISMATCH_LIMIT: mismatch_ns = pwdata_i[RegW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        item.op         = operation_i;
        item.kind       = media_kind_i;
        item.generation = generation_i;
        item.src        = source_time_i;
        item.arr        = arrival_time_i;
        item.now        = now_time_i;
        pending_results.push_back(rebase_step(item));
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no item pending: status %0d", status_i);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatches++;
          end
          if (mapped_valid_i !== want.mvalid) begin
            $error("mapped_valid: expected %0d, got %0d", want.mvalid, mapped_valid_i);
            mismatches++;
          end
          if (mapped_time_i !== want.mtime) begin
            $error("mapped_time: expected %0d, got %0d", want.mtime, mapped_time_i);
            mismatches++;
          end
        end
      end
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// ----- tb/sv/media_timestamp_rebaser_tb.sv -----
// Testbench top for media_timestamp_rebaser: clock, reset, APB setup, directed and
// session-shaped random traffic with random idling; verdict from mtr_checker.
// Depends on mtr_pkg, mtr_checker and the RTL top.
module media_timestamp_rebaser_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mtr_pkg::*;

  typedef logic [TimeW-1:0] stamp_t;

  localparam int unsigned     CycleLimit  = 400000;
  localparam int unsigned     RandItems   = 1800;
  localparam int unsigned     NumPhases   = 8;
  localparam logic [RegW-1:0] RegMax      = {RegW{1'b1}};
  localparam logic [2:0]      OpReserved5 = 3'd5;
  localparam logic [2:0]      OpReserved7 = 3'd7;
  localparam logic            KindAudio   = 1'b0;
  localparam logic            KindVideo   = 1'b1;

  logic clk = 1'b0;
  logic rst_n;

  logic             psel, penable, pwrite, pready;
  logic [ApbAW-1:0] paddr;
  logic [ApbDW-1:0] pwdata, prdata;

  logic       in_valid, in_stall;
  logic [2:0] operation;
  logic       media_kind;
  stamp_t     generation, source_time, arrival_time, now_time;

  logic       out_valid, out_stall;
  logic [3:0] status;
  logic       mapped_valid;
  stamp_t     mapped_time;

  int unsigned fail_cnt, outstanding;
  int unsigned cycle_cnt = 0;
  int unsigned sent = 0;
  bit          in_calm = 1'b0;
  stamp_t      last_gen = '0;

  // What the stimulus side last wrote, used to aim at the limits
  logic [RegW-1:0] warm_cfg = WarmupTimeRst;
  logic [RegW-1:0] late_cfg = LateLimitRst;
  logic [RegW-1:0] mism_cfg = MismatchLimitRst;

  always #5 clk = ~clk;

  media_timestamp_rebaser u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .media_kind_i   (media_kind),
    .generation_i   (generation),
    .source_time_i  (source_time),
    .arrival_time_i (arrival_time),
    .now_time_i     (now_time),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .mapped_valid_o (mapped_valid),
    .mapped_time_o  (mapped_time)
  );

  mtr_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .media_kind_i   (media_kind),
    .generation_i   (generation),
    .source_time_i  (source_time),
    .arrival_time_i (arrival_time),
    .now_time_i     (now_time),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (status),
    .mapped_valid_i (mapped_valid),
    .mapped_time_i  (mapped_time),
    .errors_o       (fail_cnt),
    .outstanding_o  (outstanding)
  );

  function automatic stamp_t rand64();
    return {$urandom, $urandom};
  endfunction

  // Wait before the next transfer; now and then flips into a stretch with no idling
  function automatic int unsigned pause_draw(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Register value: mostly moderate, sometimes zero or full scale
  function automatic logic [RegW-1:0] cfg_pick();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return RegMax;
      default: return RegW'($urandom_range(1000, 1_000_000_000));
    endcase
  endfunction

  task automatic cfg_write(input mtr_reg_e idx, input logic [RegW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= ApbDW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [RegW-1:0] warm, input logic [RegW-1:0] lead,
                            input logic [RegW-1:0] late, input logic [RegW-1:0] mism);
    cfg_write(REG_WARMUP_TIME, warm);
    cfg_write(REG_OUTPUT_LEAD, lead);
    cfg_write(REG_LATE_LIMIT, late);
    cfg_write(REG_MISMATCH_LIMIT, mism);
    warm_cfg = warm;
    late_cfg = late;
    mism_cfg = mism;
  endtask

  // One input transfer; valid stays up across back-to-back items
  task automatic send(input logic [2:0] op, input logic kind, input stamp_t gen,
                      input stamp_t src, input stamp_t arr, input stamp_t now);
    int unsigned idle;
    idle = pause_draw(in_calm);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    media_kind   <= kind;
    generation   <= gen;
    source_time  <= src;
    arrival_time <= arr;
    now_time     <= now;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Stop sending and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Session start, first-packet offers, polls, then a run of maps, projections and random operations
  task automatic run_session();
    stamp_t      gen, src0, arr0, src, arr, now, step;
    stamp_t      s_cur [2];
    stamp_t      a_cur [2];
    logic        k, lead_kind;
    logic [2:0]  op;
    int unsigned roll;
    gen = ($urandom_range(0, 5) == 0) ? last_gen : rand64();
    send(OP_SESSION, 1'($urandom), gen, rand64(), rand64(), rand64());
    last_gen = gen;

    case ($urandom_range(0, 9))
      0:       arr0 = TimeMax - stamp_t'($urandom_range(0, 2_000_000_000));
      1:       arr0 = stamp_t'($urandom_range(0, 1000));
      default: arr0 = {$urandom_range(0, 4095), $urandom};
    endcase
    case ($urandom_range(0, 9))
      0:       src0 = TimeMax - stamp_t'($urandom_range(0, 2_000_000_000));
      1:       src0 = stamp_t'($urandom_range(0, 1000));
      default: src0 = {$urandom_range(0, 65535), $urandom};
    endcase
    for (int i = 0; i < 2; i++) begin
      s_cur[i] = src0 + stamp_t'($urandom_range(0, 20_000_000));
      a_cur[i] = arr0 + stamp_t'($urandom_range(0, 20_000_000));
    end

    // offers in random order, a stream sometimes missing
    lead_kind = 1'($urandom);
    for (int i = 0; i < 2; i++) begin
      k = lead_kind ^ i[0];
      if ($urandom_range(0, 9) != 0) send(OP_OFFER, k, rand64(), s_cur[k], a_cur[k], a_cur[k]);
    end

    // polls stepping through the warmup window
    now = arr0 + 25_000_000;
    repeat ($urandom_range(1, 3)) begin
      send(OP_POLL, 1'($urandom), rand64(), rand64(), rand64(), now);
      now = now + stamp_t'(warm_cfg) / 2 + stamp_t'($urandom_range(0, 10_000_000));
    end

    // packets with mostly steady clocks and some disturbances
    repeat ($urandom_range(8, 40)) begin
      k        = 1'($urandom);
      step     = stamp_t'($urandom_range(0, 40_000_000));
      s_cur[k] = s_cur[k] + step;
      a_cur[k] = a_cur[k] + step + stamp_t'($urandom_range(0, 500_000));
      src      = s_cur[k];
      arr      = a_cur[k];
      now      = arr + stamp_t'($urandom_range(0, 2_000_000));
      op       = OP_MAP;
      roll     = $urandom_range(0, 99);
      if (roll < 4) begin
        src = s_cur[k] - stamp_t'(late_cfg) - stamp_t'($urandom_range(1, 1_000_000));
      end else if (roll < 8) begin
        arr = arr + stamp_t'(mism_cfg) + stamp_t'($urandom_range(1, 1_000_000));
      end else if (roll < 11) begin
        now = now + stamp_t'(late_cfg) + stamp_t'($urandom_range(1, 1_000_000));
      end else if (roll < 13) begin
        src = rand64();
      end else if (roll < 16) begin
        src = s_cur[k] - stamp_t'($urandom_range(1, 5_000_000));
      end else if (roll < 24) begin
        op  = OP_PROJECT;
        src = ($urandom_range(0, 7) == 0) ? rand64() :
              s_cur[k] - stamp_t'($urandom_range(0, 100_000_000));
      end
      if (roll >= 97) begin
        send(3'($urandom_range(0, 7)), 1'($urandom), rand64(), rand64(), rand64(), rand64());
      end else begin
        send(op, k, rand64(), src, arr, now);
      end
    end
  endtask

  // Result side: stalls a random number of cycles before taking each result
  initial begin : result_side
    int unsigned hold;
    bit          calm;
    calm = 1'b0;
    forever begin
      hold = pause_draw(calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[media_timestamp_rebaser] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned rand_base;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid     <= 1'b0;
    operation    <= OP_SESSION;
    media_kind   <= KindAudio;
    generation   <= '0;
    source_time  <= '0;
    arrival_time <= '0;
    now_time     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset configuration, empty session
    send(OP_MAP, KindAudio, '0, 100, 100, 100);                 // map before ready
    send(OP_PROJECT, KindVideo, '0, 100, 100, 100);             // projection before ready
    send(OP_POLL, KindAudio, '0, '0, '0, '0);                   // poll before any offer
    send(OpReserved5, KindVideo, TimeMax, TimeMax, TimeMax, TimeMax);
    send(OpReserved7, KindAudio, '0, '0, '0, '0);
    send(OP_SESSION, KindAudio, '0, '0, '0, '0);                // first generation
    send(OP_SESSION, KindVideo, '0, '0, '0, '0);                // repeat of it
    send(OP_SESSION, KindAudio, TimeMax, '0, '0, '0);
    send(OP_OFFER, KindVideo, '0, 2_000_000_000, 10_000, 0);    // video first
    send(OP_POLL, KindAudio, '0, '0, '0, 20_000);               // still warming
    send(OP_OFFER, KindVideo, '0, 5, 5, 5);                     // second video offer ignored
    send(OP_POLL, KindVideo, '0, '0, '0, 500_010_000);          // warmup over, one stream
    send(OP_POLL, KindAudio, '0, '0, '0, '0);                   // already ready
    send(OP_OFFER, KindAudio, '0, 1_000_000_000, 600_000_000, 0);
    send(OP_MAP, KindVideo, '0, 2_000_000_000, 10_000, 500_010_000);
    send(OP_MAP, KindAudio, '0, 1_999_000_000, 9_000, 500_010_000);  // below origin
    send(OP_MAP, KindVideo, '0, 2_010_000_000, 10_010_000, 510_000_000);
    send(OP_MAP, KindVideo, '0, 2_020_000_000, 3_000_000_000, 520_000_000);  // clock jump
    send(OP_MAP, KindVideo, '0, 100, 3_000_000_100, 520_000_000);     // far backwards
    send(OP_MAP, KindAudio, '0, 2_030_000_000, 3_000_000_000, TimeMax);  // very late
    send(OP_PROJECT, KindAudio, '0, '0, '0, '0);
    send(OP_PROJECT, KindVideo, '0, TimeMax, '0, '0);
    send(OP_PROJECT, KindVideo, '0, 2_025_000_000, '0, '0);
    send(OP_MAP, KindVideo, '0, TimeMax, TimeMax, TimeMax);           // saturated origin
    send(OP_SESSION, KindVideo, 1, '0, '0, '0);

    // Random phases, each under its own configuration
    rand_base = sent;
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0:       set_config('0, '0, '0, '0);
        1:       set_config(RegMax, RegMax, RegMax, RegMax);
        default: set_config(cfg_pick(), cfg_pick(), cfg_pick(), cfg_pick());
      endcase
      while (sent < rand_base + (ph + 1) * (RandItems / NumPhases)) run_session();
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("[media_timestamp_rebaser] OK");
    end else begin
      $display("[media_timestamp_rebaser] ERROR");
    end
    $finish;
  end

endmodule
